>>> rtl/core/xees_pkg.sv
// Shared types, character codes and marker tables for the XML element end scanner.
`timescale 1ns / 1ps

package xees_pkg;

    localparam int OUT_OFF_W = 20;
    localparam int MATCH_W   = 4;

    localparam logic [MATCH_W-1:0] CDATA_LEN   = 4'd9;
    localparam logic [MATCH_W-1:0] COMMENT_LEN = 4'd4;
    localparam logic [MATCH_W-1:0] SPLIT_IDX   = 4'd3;

    localparam logic [7:0] CH_LT       = 8'h3C;
    localparam logic [7:0] CH_GT       = 8'h3E;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_DASH     = 8'h2D;
    localparam logic [7:0] CH_BANG     = 8'h21;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;

    localparam logic [1:0] CLOSER_FULL = 2'd2;

    typedef enum logic [3:0] {
        PH_NORMAL,
        PH_LT,
        PH_LT_CD,
        PH_LT_CM,
        PH_SLASH,
        PH_QUOTE,
        PH_ESC,
        PH_IN_CD,
        PH_IN_CM
    } scan_phase_t;

    typedef enum logic [2:0] {
        ST_CLOSE_TAG,
        ST_SELF_CLOSE,
        ST_TEXT_END,
        ST_OPEN_COMMENT,
        ST_OPEN_CDATA,
        ST_DEPTH_OVERFLOW
    } end_status_t;

    typedef struct packed {
        logic                 have;
        end_status_t          status;
        logic [OUT_OFF_W-1:0] offset;
    } scan_result_t;

    // Characters of the CDATA opener, indexed by match position.
    function automatic logic [7:0] cdata_char(input logic [MATCH_W-1:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0: ch = CH_LT;
            4'd1: ch = CH_BANG;
            4'd2: ch = CH_LBRACKET;
            4'd3: ch = 8'h43;
            4'd4: ch = 8'h44;
            4'd5: ch = 8'h41;
            4'd6: ch = 8'h54;
            4'd7: ch = 8'h41;
            4'd8: ch = CH_LBRACKET;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Characters of the comment opener, indexed by match position.
    function automatic logic [7:0] comment_char(input logic [MATCH_W-1:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0: ch = CH_LT;
            4'd1: ch = CH_BANG;
            4'd2: ch = CH_DASH;
            4'd3: ch = CH_DASH;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> rtl/core/xees_scan_core.sv
// Scan state registers and the per-byte update logic of the element end scanner.
`timescale 1ns / 1ps

module xees_scan_core
    import xees_pkg::*;
#(
    parameter int OFFSET_BITS = 20,
    parameter int MAX_DEPTH   = 255
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step_en,
    input  logic [7:0]   text_byte,
    input  logic         scan_start,
    input  logic         text_last,
    output scan_result_t result
);

    localparam int LEVEL_BITS = $clog2(MAX_DEPTH + 1);
    localparam logic [LEVEL_BITS-1:0] MAX_LEVEL = LEVEL_BITS'(MAX_DEPTH);

    scan_phase_t             phase_reg,  phase_next;
    logic [MATCH_W-1:0]      match_reg,  match_next;
    logic [LEVEL_BITS-1:0]   level_reg,  level_next;
    logic [OFFSET_BITS-1:0]  boff_reg,   boff_next;
    logic [OFFSET_BITS-1:0]  moff_reg,   moff_next;
    logic [1:0]              closer_reg, closer_next;
    logic                    fin_reg,    fin_next;

    logic [OFFSET_BITS-1:0]  cur_off;
    logic [OFFSET_BITS-1:0]  rep_off;
    logic                    have;
    end_status_t             status;
    logic                    do_normal;
    logic                    cd_ok;
    logic                    cm_ok;
    logic [OFFSET_BITS+OUT_OFF_W-1:0] rep_off_wide;

    always_comb begin
        phase_next  = scan_start ? PH_NORMAL : phase_reg;
        match_next  = scan_start ? '0 : match_reg;
        level_next  = scan_start ? '0 : level_reg;
        boff_next   = scan_start ? '0 : boff_reg;
        moff_next   = scan_start ? '0 : moff_reg;
        closer_next = scan_start ? '0 : closer_reg;
        fin_next    = scan_start ? 1'b0 : fin_reg;
        cur_off     = boff_next;
        have        = 1'b0;
        status      = ST_CLOSE_TAG;
        rep_off     = '0;
        do_normal   = 1'b0;
        cd_ok       = 1'b0;
        cm_ok       = 1'b0;

        if (!fin_next) begin
            boff_next = cur_off + 1'b1;
            case (phase_next)
                PH_LT, PH_LT_CD, PH_LT_CM: begin
                    if (phase_next == PH_LT && match_next == 4'd1 && text_byte == CH_SLASH) begin
                        if (level_next == '0) begin
                            have     = 1'b1;
                            status   = ST_CLOSE_TAG;
                            rep_off  = moff_next;
                            fin_next = 1'b1;
                        end else begin
                            level_next = level_next - 1'b1;
                            do_normal  = 1'b1;
                        end
                    end else begin
                        cd_ok = phase_next != PH_LT_CM && match_next < CDATA_LEN
                                && text_byte == cdata_char(match_next);
                        cm_ok = phase_next != PH_LT_CD && match_next < COMMENT_LEN
                                && text_byte == comment_char(match_next);
                        if (cd_ok) begin
                            match_next = match_next + 1'b1;
                            if (match_next == CDATA_LEN) begin
                                phase_next  = PH_IN_CD;
                                closer_next = '0;
                            end else begin
                                phase_next = (match_next >= SPLIT_IDX) ? PH_LT_CD : PH_LT;
                            end
                        end else if (cm_ok) begin
                            match_next = match_next + 1'b1;
                            if (match_next == COMMENT_LEN) begin
                                // The opener's dashes already count toward the closer.
                                phase_next  = PH_IN_CM;
                                closer_next = CLOSER_FULL;
                            end else begin
                                phase_next = (match_next >= SPLIT_IDX) ? PH_LT_CM : PH_LT;
                            end
                        end else begin
                            // The pending '<' was an opening tag after all.
                            if (level_next == MAX_LEVEL) begin
                                have     = 1'b1;
                                status   = ST_DEPTH_OVERFLOW;
                                rep_off  = moff_next;
                                fin_next = 1'b1;
                            end else begin
                                level_next = level_next + 1'b1;
                            end
                            do_normal = 1'b1;
                        end
                    end
                end
                PH_SLASH: begin
                    if (text_byte == CH_GT) begin
                        if (level_next == '0) begin
                            have     = 1'b1;
                            status   = ST_SELF_CLOSE;
                            rep_off  = moff_next;
                            fin_next = 1'b1;
                        end else begin
                            level_next = level_next - 1'b1;
                        end
                    end
                    do_normal = 1'b1;
                end
                PH_QUOTE: begin
                    if (text_byte == CH_BSLASH) begin
                        phase_next = PH_ESC;
                    end else if (text_byte == CH_QUOTE) begin
                        phase_next = PH_NORMAL;
                    end
                end
                PH_ESC: begin
                    phase_next = PH_QUOTE;
                end
                PH_IN_CD, PH_IN_CM: begin
                    if (text_byte == ((phase_next == PH_IN_CD) ? CH_RBRACKET : CH_DASH)) begin
                        if (closer_next < CLOSER_FULL) begin
                            closer_next = closer_next + 1'b1;
                        end
                    end else if (text_byte == CH_GT && closer_next == CLOSER_FULL) begin
                        closer_next = '0;
                        phase_next  = PH_NORMAL;
                    end else begin
                        closer_next = '0;
                    end
                end
                default: begin
                    do_normal = 1'b1;
                end
            endcase

            if (do_normal && !fin_next) begin
                if (text_byte == CH_LT) begin
                    phase_next = PH_LT;
                    match_next = 4'd1;
                    moff_next  = cur_off;
                end else if (text_byte == CH_SLASH) begin
                    phase_next = PH_SLASH;
                    moff_next  = cur_off;
                end else if (text_byte == CH_QUOTE) begin
                    phase_next = PH_QUOTE;
                end else begin
                    phase_next = PH_NORMAL;
                end
            end

            if (!fin_next && text_last) begin
                if (phase_next == PH_LT || phase_next == PH_LT_CD || phase_next == PH_LT_CM) begin
                    if (level_next == MAX_LEVEL) begin
                        have     = 1'b1;
                        status   = ST_DEPTH_OVERFLOW;
                        rep_off  = moff_next;
                        fin_next = 1'b1;
                    end else begin
                        level_next = level_next + 1'b1;
                    end
                end
                if (!fin_next) begin
                    have     = 1'b1;
                    rep_off  = boff_next;
                    fin_next = 1'b1;
                    if (phase_next == PH_IN_CD) begin
                        status = ST_OPEN_CDATA;
                    end else if (phase_next == PH_IN_CM) begin
                        status = ST_OPEN_COMMENT;
                    end else begin
                        status = ST_TEXT_END;
                    end
                end
            end
        end
    end

    // Offsets are reported in a fixed 20-bit field whatever the counter width.
    assign rep_off_wide  = {{OUT_OFF_W{1'b0}}, rep_off};
    assign result.have   = step_en && have;
    assign result.status = status;
    assign result.offset = rep_off_wide[OUT_OFF_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_NORMAL;
            match_reg  <= '0;
            level_reg  <= '0;
            boff_reg   <= '0;
            moff_reg   <= '0;
            closer_reg <= '0;
            fin_reg    <= 1'b1;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            match_reg  <= match_next;
            level_reg  <= level_next;
            boff_reg   <= boff_next;
            moff_reg   <= moff_next;
            closer_reg <= closer_next;
            fin_reg    <= fin_next;
        end
    end

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= MAX_LEVEL)
        else $error("nesting level above maximum depth");

    a_result_finishes: assert property (@(posedge aclk) disable iff (!aresetn)
        result.have |=> fin_reg)
        else $error("scan still open after reporting its end");

    a_idle_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_reg && !scan_start |-> !have)
        else $error("result produced while idle");

endmodule

>>> rtl/core/xml_element_end_scanner.sv
// Top level of the XML element end scanner: input register, scan core, result register.
//
// Usage: text streams in on the s_ channel one byte per word, with s_scan_start
// on the byte just inside the opened element and s_text_last on the final byte.
// Each scan yields at most one word on the m_ channel: m_end_status says how
// the scan ended (closing tag, self-close, end of text, open comment, open
// CDATA, depth overflow) and m_end_offset gives the byte offset from the start.
// Bytes outside a scan are consumed and ignored.
// A byte is scanned from the input register straight into the result register.
// Throughput: one byte per cycle while no result waits on a low m_ready; the scan
// state update for a byte is combinational between the input register and the
// result register.
// When m_ready is low with a result waiting, one more byte is still taken into
// the input register; further bytes wait until the result is taken.
// Reset (aresetn low, synchronous) empties both registers and puts the
// scanner idle until a byte with s_scan_start arrives.
`timescale 1ns / 1ps

module xml_element_end_scanner
    import xees_pkg::*;
#(
    parameter int OFFSET_BITS = 20,
    parameter int MAX_DEPTH   = 255
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_text_byte,
    input  logic                 s_scan_start,
    input  logic                 s_text_last,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_end_status,
    output logic [OUT_OFF_W-1:0] m_end_offset
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_start_reg;
    logic                 in_last_reg;
    logic                 m_valid_reg;
    end_status_t          m_status_reg;
    logic [OUT_OFF_W-1:0] m_offset_reg;
    logic                 step_en;
    scan_result_t         result;

    // A held word is processed once the result register can take its outcome.
    assign step_en = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step_en) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_text_byte;
            in_start_reg <= s_scan_start;
            in_last_reg  <= s_text_last;
        end
    end

    xees_scan_core #(
        .OFFSET_BITS(OFFSET_BITS),
        .MAX_DEPTH  (MAX_DEPTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .text_byte (in_byte_reg),
        .scan_start(in_start_reg),
        .text_last (in_last_reg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result.have) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.have) begin
            m_status_reg <= result.status;
            m_offset_reg <= result.offset;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_end_status = m_status_reg;
    assign m_end_offset = m_offset_reg;

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        result.have |=> m_valid_reg)
        else $error("scan result not captured");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_status_reg <= ST_DEPTH_OVERFLOW)
        else $error("end status out of range");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !result.have)
        else $error("pending result overwritten");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the XML element end scanner with random flow control.
`timescale 1ns / 1ps

module testbench;
    import xees_pkg::*;

    localparam int OFFSET_BITS  = 20;
    localparam int MAX_NEST     = 255;
    localparam int TEXT_WORDS   = 1050;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_SPACING = 500;
    localparam int MAX_REPORTS  = 10;
    localparam longint TIMEOUT_NS = 2_000_000;

    localparam logic [7:0] CDATA_OPENER [16] = '{0: CH_LT, 1: CH_BANG, 2: CH_LBRACKET,
        3: 8'h43, 4: 8'h44, 5: 8'h41, 6: 8'h54, 7: 8'h41, 8: CH_LBRACKET, default: 8'h00};
    localparam logic [7:0] COMMENT_OPENER [16] = '{0: CH_LT, 1: CH_BANG, 2: CH_DASH,
        3: CH_DASH, default: 8'h00};

    typedef struct packed {
        scan_phase_t            phase;
        logic [MATCH_W-1:0]     match_idx;
        logic [7:0]             level;
        logic [OFFSET_BITS-1:0] offset;
        logic [OFFSET_BITS-1:0] marker;
        logic [1:0]             closer_cnt;
        logic                   done;
        scan_result_t           res;
    } scan_ctx_t;

    localparam scan_ctx_t CTX_IDLE = '{phase: PH_NORMAL, match_idx: '0, level: '0,
        offset: '0, marker: '0, closer_cnt: '0, done: 1'b1, res: '0};

    typedef struct packed {
        logic [7:0] text;
        logic       start;
        logic       last;
        logic       drain;
    } text_word_t;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_pattern_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_text_byte = 8'h00;
    logic                 s_scan_start = 1'b0;
    logic                 s_text_last = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [2:0]           m_end_status;
    logic [OUT_OFF_W-1:0] m_end_offset;

    text_word_t   pending_words[$];
    scan_result_t pending_ends[$];
    logic [7:0]   scan_text[$];
    scan_ctx_t    tracker = CTX_IDLE;
    scan_ctx_t    gen_ctx = CTX_IDLE;
    logic         drain_next = 1'b0;
    logic         in_taken = 1'b0;
    int           live_words = 0;
    int           words_in = 0;
    int           ends_seen = 0;
    int           error_count = 0;
    int           end_counts[6];
    int           gap_left = 0;
    int           burst_left = 1;
    int           hold_left = 0;
    int           next_hold_at = 400;
    int           mode_left = 0;
    int           rx_cycle = 0;
    rx_pattern_t  rx_mode = RX_ALWAYS;

    always #2 aclk = ~aclk;

    xml_element_end_scanner #(
        .OFFSET_BITS(OFFSET_BITS),
        .MAX_DEPTH  (MAX_NEST)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_text_byte (s_text_byte),
        .s_scan_start(s_scan_start),
        .s_text_last (s_text_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_end_status(m_end_status),
        .m_end_offset(m_end_offset)
    );

    function automatic void finish_scan(inout scan_ctx_t st, input end_status_t code,
                                        input logic [OFFSET_BITS-1:0] at);
        st.res.have   = 1'b1;
        st.res.status = code;
        st.res.offset = OUT_OFF_W'(at);
        st.done       = 1'b1;
    endfunction

    function automatic void open_nest(inout scan_ctx_t st);
        if (st.level >= MAX_NEST)
            finish_scan(st, ST_DEPTH_OVERFLOW, st.marker);
        else
            st.level = st.level + 8'd1;
    endfunction

    function automatic void plain_byte(inout scan_ctx_t st, input logic [7:0] ch,
                                       input logic [OFFSET_BITS-1:0] pos);
        case (ch)
            CH_LT: begin
                st.phase     = PH_LT;
                st.match_idx = 4'd1;
                st.marker    = pos;
            end
            CH_SLASH: begin
                st.phase  = PH_SLASH;
                st.marker = pos;
            end
            CH_QUOTE: st.phase = PH_QUOTE;
            default:  st.phase = PH_NORMAL;
        endcase
    endfunction

    function automatic void closer_step(inout scan_ctx_t st, input logic [7:0] ch,
                                        input logic [7:0] run_ch);
        if (ch == run_ch) begin
            if (st.closer_cnt < CLOSER_FULL)
                st.closer_cnt = st.closer_cnt + 2'd1;
        end else if (ch == CH_GT && st.closer_cnt == CLOSER_FULL) begin
            st.closer_cnt = '0;
            st.phase      = PH_NORMAL;
        end else begin
            st.closer_cnt = '0;
        end
    endfunction

    // Advances the scan by one byte; st.res.have tells whether the scan ended on it.
    function automatic void scan_byte(inout scan_ctx_t st, input logic [7:0] ch,
                                      input logic start, input logic last);
        logic [OFFSET_BITS-1:0] pos;
        logic cd_ok;
        logic cm_ok;
        st.res.have = 1'b0;
        if (start) begin
            st.phase      = PH_NORMAL;
            st.match_idx  = '0;
            st.level      = '0;
            st.offset     = '0;
            st.marker     = '0;
            st.closer_cnt = '0;
            st.done       = 1'b0;
        end
        if (st.done)
            return;
        pos = st.offset;
        st.offset = st.offset + 1'b1;
        case (st.phase)
            PH_LT, PH_LT_CD, PH_LT_CM: begin
                if (st.phase == PH_LT && st.match_idx == 4'd1 && ch == CH_SLASH) begin
                    // The slash of a closing tag may also start a self-close.
                    if (st.level == 0) begin
                        finish_scan(st, ST_CLOSE_TAG, st.marker);
                    end else begin
                        st.level = st.level - 8'd1;
                        plain_byte(st, ch, pos);
                    end
                end else begin
                    cd_ok = st.phase != PH_LT_CM && st.match_idx < CDATA_LEN
                            && ch == CDATA_OPENER[st.match_idx];
                    cm_ok = st.phase != PH_LT_CD && st.match_idx < COMMENT_LEN
                            && ch == COMMENT_OPENER[st.match_idx];
                    if (cd_ok) begin
                        st.match_idx = st.match_idx + 1'b1;
                        if (st.match_idx == CDATA_LEN) begin
                            st.phase      = PH_IN_CD;
                            st.closer_cnt = '0;
                        end else begin
                            st.phase = (st.match_idx >= SPLIT_IDX) ? PH_LT_CD : PH_LT;
                        end
                    end else if (cm_ok) begin
                        st.match_idx = st.match_idx + 1'b1;
                        if (st.match_idx == COMMENT_LEN) begin
                            // The dashes of the opener already count toward the closer.
                            st.phase      = PH_IN_CM;
                            st.closer_cnt = CLOSER_FULL;
                        end else begin
                            st.phase = (st.match_idx >= SPLIT_IDX) ? PH_LT_CM : PH_LT;
                        end
                    end else begin
                        open_nest(st);
                        if (!st.done)
                            plain_byte(st, ch, pos);
                    end
                end
            end
            PH_SLASH: begin
                if (ch == CH_GT && st.level == 0) begin
                    finish_scan(st, ST_SELF_CLOSE, st.marker);
                end else begin
                    if (ch == CH_GT)
                        st.level = st.level - 8'd1;
                    plain_byte(st, ch, pos);
                end
            end
            PH_QUOTE: begin
                if (ch == CH_BSLASH)
                    st.phase = PH_ESC;
                else if (ch == CH_QUOTE)
                    st.phase = PH_NORMAL;
            end
            PH_ESC:   st.phase = PH_QUOTE;
            PH_IN_CD: closer_step(st, ch, CH_RBRACKET);
            PH_IN_CM: closer_step(st, ch, CH_DASH);
            default:  plain_byte(st, ch, pos);
        endcase
        if (!st.done && last) begin
            if (st.phase inside {PH_LT, PH_LT_CD, PH_LT_CM})
                open_nest(st);
            if (!st.done) begin
                case (st.phase)
                    PH_IN_CD: finish_scan(st, ST_OPEN_CDATA, st.offset);
                    PH_IN_CM: finish_scan(st, ST_OPEN_COMMENT, st.offset);
                    default:  finish_scan(st, ST_TEXT_END, st.offset);
                endcase
            end
        end
    endfunction

    function automatic logic [7:0] rand_letter();
        return 8'($urandom_range(97, 122));
    endfunction

    task automatic put_byte(input logic [7:0] b);
        scan_text.push_back(b);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            scan_text.push_back(s[i]);
    endtask

    task automatic put_word(input logic [7:0] b, input logic start, input logic last);
        text_word_t w;
        w = '{text: b, start: start, last: last, drain: drain_next};
        drain_next = 1'b0;
        if (start || !gen_ctx.done)
            live_words++;
        scan_byte(gen_ctx, b, start, last);
        pending_words.push_back(w);
    endtask

    task automatic flush_scan(input logic with_last);
        for (int i = 0; i < scan_text.size(); i++)
            put_word(scan_text[i], i == 0, with_last && i == scan_text.size() - 1);
        scan_text.delete();
    endtask

    task automatic add_token();
        int roll;
        int n;
        int k;
        string opener;
        string specials;
        specials = "<>/\"\\]-![";
        roll = $urandom_range(0, 99);
        n = $urandom_range(1, 4);
        if (roll < 22) begin
            repeat (n) put_byte(rand_letter());
        end else if (roll < 38) begin
            put_byte(CH_LT);
            repeat (n) put_byte(rand_letter());
            if ($urandom_range(0, 2) == 0) begin
                put_str(" k=\"");
                repeat (n) put_byte(rand_letter());
                put_byte(CH_QUOTE);
            end
            if ($urandom_range(0, 3) == 0)
                put_str("/>");
            else
                put_byte(CH_GT);
        end else if (roll < 50) begin
            put_str("</");
            repeat (n) put_byte(rand_letter());
            put_byte(CH_GT);
        end else if (roll < 55) begin
            put_str("/>");
        end else if (roll < 63) begin
            put_byte(CH_QUOTE);
            repeat (n) begin
                case ($urandom_range(0, 3))
                    0: begin
                        put_byte(CH_BSLASH);
                        put_byte(8'($urandom_range(0, 255)));
                    end
                    1: put_byte(specials[$urandom_range(0, specials.len() - 1)]);
                    default: put_byte(rand_letter());
                endcase
            end
            put_byte(CH_QUOTE);
        end else if (roll < 70) begin
            put_str("<!--");
            repeat (n) put_byte(specials[$urandom_range(0, specials.len() - 1)]);
            put_str($urandom_range(0, 2) == 0 ? "--->" : "-->");
        end else if (roll < 77) begin
            put_str("<![CDATA[");
            repeat (n) put_byte(specials[$urandom_range(0, specials.len() - 1)]);
            put_str($urandom_range(0, 2) == 0 ? "]]]>" : "]]>");
        end else if (roll < 85) begin
            // An opener that breaks off part way and falls back to a plain tag.
            opener = $urandom_range(0, 1) ? "<![CDATA[" : "<!--";
            k = $urandom_range(1, opener.len() - 1);
            for (int i = 0; i < k; i++)
                put_byte(opener[i]);
            put_byte(specials[$urandom_range(0, specials.len() - 1)]);
        end else if (roll < 93) begin
            repeat (n) put_byte(8'($urandom_range(0, 255)));
        end else begin
            put_byte(specials[$urandom_range(0, specials.len() - 1)]);
        end
    endtask

    task automatic add_open_tail();
        case ($urandom_range(0, 3))
            0: put_str("<!--");
            1: put_str("<![CDATA[");
            2: put_str("\"");
            default: put_str($urandom_range(0, 1) ? "<!" : "<![CD");
        endcase
        repeat ($urandom_range(0, 3)) put_byte(rand_letter());
        if ($urandom_range(0, 3) == 0)
            put_byte(CH_BSLASH);
    endtask

    task automatic add_random_scan();
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(10, 40)) put_str("<a>");
        repeat ($urandom_range(1, 20)) add_token();
        case ($urandom_range(0, 3))
            0: begin
                add_open_tail();
                flush_scan(1'b1);
            end
            1: flush_scan(1'b1);
            default: flush_scan(1'b0);
        endcase
        // Loose bytes outside a scan, or trailing bytes of an unfinished one.
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
                put_word(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
    endtask

    // Sender: bursts of words separated by random gaps.
    always @(negedge aclk) begin
        text_word_t w;
        logic offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            offer = 1'b0;
            if (gap_left != 0) begin
                gap_left--;
            end else if (pending_words.size() != 0
                         && !(pending_words[0].drain && pending_ends.size() != 0)) begin
                w = pending_words.pop_front();
                offer = 1'b1;
                s_text_byte  <= w.text;
                s_scan_start <= w.start;
                s_text_last  <= w.last;
                if (burst_left <= 1) begin
                    burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end
            s_valid <= offer;
        end
    end

    // Receiver: changing stall patterns, with a long hold-off now and then.
    always @(negedge aclk) begin
        logic rdy;
        rdy = 1'b0;
        rx_cycle++;
        if (aresetn) begin
            if (hold_left != 0) begin
                hold_left--;
            end else if (words_in >= next_hold_at) begin
                hold_left    = HOLD_CYCLES;
                next_hold_at = next_hold_at + HOLD_SPACING;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = rx_pattern_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    RX_ALWAYS: rdy = 1'b1;
                    RX_COIN:   rdy = 1'($urandom_range(0, 1));
                    RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                    default:   rdy = (rx_cycle % 3 != 0);
                endcase
            end
        end
        m_ready <= rdy;
    end

    // Checker: compare each result word, then predict from the accepted text word.
    always @(posedge aclk) begin
        scan_result_t want;
        in_taken = aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (pending_ends.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("ERROR: unexpected scan end: status %0d offset %0d",
                             m_end_status, m_end_offset);
            end else begin
                want = pending_ends.pop_front();
                if (m_end_status !== want.status || m_end_offset !== want.offset) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("ERROR: scan end %0d: expected status %0d offset %0d, %s",
                                 ends_seen, want.status, want.offset,
                                 $sformatf("got status %0d offset %0d",
                                           m_end_status, m_end_offset));
                end
                end_counts[want.status]++;
                ends_seen++;
            end
        end
        if (in_taken) begin
            words_in++;
            scan_byte(tracker, s_text_byte, s_scan_start, s_text_last);
            if (tracker.res.have)
                pending_ends.push_back(tracker.res);
        end
    end

    initial begin
        int scan_no;
        foreach (end_counts[i])
            end_counts[i] = 0;

        // Directed scans: every way a scan ends, plus the corner cases of the syntax.
        put_word(8'hFF, 1'b0, 1'b1);
        put_str("ab</");                    flush_scan(1'b0);
        put_word(8'h00, 1'b0, 1'b0);
        put_str("<a/>x/>");                 flush_scan(1'b0);
        put_str("<!--></");                 flush_scan(1'b0);
        put_str("<![CDATA[]]]></");         flush_scan(1'b0);
        put_str("\"a\\\"</\"</");           flush_scan(1'b0);
        put_str("\"ab");                    flush_scan(1'b1);
        put_str("\"\\");                    flush_scan(1'b1);
        put_str("<!-");                     flush_scan(1'b1);
        put_str("<!--ab-");                 flush_scan(1'b1);
        put_str("<![CDATA[x");              flush_scan(1'b1);
        put_byte(8'h00); put_str("</");     flush_scan(1'b0);
        put_word(8'hFF, 1'b1, 1'b1);
        put_str("<a");                      flush_scan(1'b0);
        put_str("/>");                      flush_scan(1'b0);
        put_str("<a</>");                   flush_scan(1'b0);
        put_str("<!-x</</");                flush_scan(1'b0);
        drain_next = 1'b1;
        repeat (MAX_NEST + 1) put_byte(CH_LT);
        put_byte("x");                      flush_scan(1'b0);
        repeat (MAX_NEST + 1) put_byte(CH_LT);
        flush_scan(1'b1);

        // Random scans fill up the rest of the text budget.
        scan_no = 0;
        while (live_words < TEXT_WORDS) begin
            if (scan_no % 150 == 75)
                drain_next = 1'b1;
            add_random_scan();
            scan_no++;
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        while (pending_words.size() != 0 || s_valid)
            @(posedge aclk);
        @(negedge aclk);
        while (pending_ends.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Ran %0d text words through %0d scans; %0d scan ends checked.",
                 words_in, scan_no + 18, ends_seen);
        $display("Ends by kind: close %0d, self-close %0d, text end %0d, %s",
                 end_counts[ST_CLOSE_TAG], end_counts[ST_SELF_CLOSE],
                 end_counts[ST_TEXT_END],
                 $sformatf("open comment %0d, open CDATA %0d, overflow %0d",
                           end_counts[ST_OPEN_COMMENT], end_counts[ST_OPEN_CDATA],
                           end_counts[ST_DEPTH_OVERFLOW]));
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", error_count);
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d words and %0d ends outstanding",
                 pending_words.size(), pending_ends.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
